// ===== rtl/bhx_pkg.sv =====
// bhx_pkg: shared types and constants for the BinHex 4.0 stream decoder.
// No dependencies; used by bhx_classify, bhx_core and binhex_stream_decoder.
package bhx_pkg;

  typedef logic [6:0] code_t;
  typedef logic [1:0] status_t;

  localparam code_t CODE_END  = 7'h7F;
  localparam code_t CODE_SKIP = 7'h7E;
  localparam code_t CODE_BAD  = 7'h7D;

  localparam logic [7:0] RUN_MARK = 8'h90;
  localparam logic [7:0] START_CH = 8'h3A;

  localparam status_t ST_DATA  = 2'd0;
  localparam status_t ST_END   = 2'd1;
  localparam status_t ST_ABORT = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic [7:0] repeat_res;
    status_t    status;
  } res_t;

endpackage

// ===== rtl/bhx_classify.sv =====
// bhx_classify: maps one BinHex text character to a 6-bit value or a marker code.
// Depends on bhx_pkg.
module bhx_classify (
  input  logic [7:0]     ch,
  output bhx_pkg::code_t code
);

  always_comb begin
    case (ch) inside
      8'h09, 8'h0A, 8'h0D, 8'h20: code = bhx_pkg::CODE_SKIP;
      bhx_pkg::START_CH:          code = bhx_pkg::CODE_END;
      [8'h21:8'h2D]:              code = 7'(ch - 8'h21);
      [8'h30:8'h36]:              code = 7'(ch - 8'h30 + 8'd13);
      [8'h38:8'h39]:              code = 7'(ch - 8'h38 + 8'd20);
      [8'h40:8'h4E]:              code = 7'(ch - 8'h40 + 8'd22);
      [8'h50:8'h56]:              code = 7'(ch - 8'h50 + 8'd37);
      [8'h58:8'h5B]:              code = 7'(ch - 8'h58 + 8'd44);
      [8'h60:8'h66]:              code = 7'(ch - 8'h60 + 8'd48);
      [8'h68:8'h6D]:              code = 7'(ch - 8'h68 + 8'd55);
      [8'h70:8'h72]:              code = 7'(ch - 8'h70 + 8'd61);
      default:                    code = bhx_pkg::CODE_BAD;
    endcase
  end

endmodule

// ===== rtl/bhx_core.sv =====
// bhx_core: decode state (mode, phase, partial bits, run tracking) and result logic.
// Depends on bhx_pkg; fed by bhx_classify.
module bhx_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  bhx_pkg::code_t code,
  input  logic           permissive,
  output bhx_pkg::res_t  res
);

  logic       mode_r, mode_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] part_r, part_nxt;
  logic       runp_r, runp_nxt;
  logic [7:0] last_r, last_nxt;

  logic [5:0] v;
  logic [7:0] data;
  logic       have_byte;

  assign v = code[5:0];

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    part_nxt  = part_r;
    runp_nxt  = runp_r;
    last_nxt  = last_r;
    res       = '0;
    data      = '0;
    have_byte = 1'b0;

    if (!mode_r) begin
      if (code == bhx_pkg::CODE_END) begin
        mode_nxt  = 1'b1;
        phase_nxt = '0;
        part_nxt  = '0;
        runp_nxt  = 1'b0;
        last_nxt  = '0;
      end
    end else if (code == bhx_pkg::CODE_SKIP) begin
      mode_nxt = mode_r;
    end else if (code == bhx_pkg::CODE_END) begin
      mode_nxt   = 1'b0;
      res.valid  = 1'b1;
      res.status = bhx_pkg::ST_END;
    end else if (code == bhx_pkg::CODE_BAD) begin
      if (!permissive) begin
        mode_nxt   = 1'b0;
        res.valid  = 1'b1;
        res.status = bhx_pkg::ST_ABORT;
      end
    end else begin
      case (phase_r)
        2'd0: begin
          part_nxt  = {v, 2'b00};
          phase_nxt = 2'd1;
        end
        2'd1: begin
          data      = part_r | {6'b0, v[5:4]};
          part_nxt  = {v[3:0], 4'b0};
          phase_nxt = 2'd2;
          have_byte = 1'b1;
        end
        2'd2: begin
          data      = part_r | {4'b0, v[5:2]};
          part_nxt  = {v[1:0], 6'b0};
          phase_nxt = 2'd3;
          have_byte = 1'b1;
        end
        default: begin
          data      = part_r | {2'b0, v};
          phase_nxt = 2'd0;
          have_byte = 1'b1;
        end
      endcase

      if (have_byte) begin
        if (!runp_r) begin
          if (data == bhx_pkg::RUN_MARK) begin
            runp_nxt = 1'b1;
          end else begin
            last_nxt       = data;
            res.valid      = 1'b1;
            res.data_byte  = data;
            res.repeat_res = 8'd1;
          end
        end else begin
          runp_nxt = 1'b0;
          if (data == 8'd0) begin
            last_nxt       = bhx_pkg::RUN_MARK;
            res.valid      = 1'b1;
            res.data_byte  = bhx_pkg::RUN_MARK;
            res.repeat_res = 8'd1;
          end else if (data != 8'd1) begin
            res.valid      = 1'b1;
            res.data_byte  = last_r;
            res.repeat_res = data - 8'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      phase_r <= '0;
      part_r  <= '0;
      runp_r  <= 1'b0;
      last_r  <= '0;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      part_r  <= part_nxt;
      runp_r  <= runp_nxt;
      last_r  <= last_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    advance && mode_r && code == bhx_pkg::CODE_END |=> !mode_r)
    else $error("end marker did not return to search");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !mode_r && code == bhx_pkg::CODE_END |=>
      mode_r && phase_r == 2'd0 && !runp_r && last_r == 8'd0)
    else $error("start marker did not clear decode state");

  a_group_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    advance && mode_r && !code[6] && phase_r == 2'd3 |=> phase_r == 2'd0)
    else $error("phase did not wrap after fourth character");

  a_repeat_last: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.valid && res.status == bhx_pkg::ST_DATA && res.repeat_res != 8'd1
      |-> runp_r && res.data_byte == last_r)
    else $error("run result does not repeat last byte");
`endif

endmodule

// ===== rtl/binhex_stream_decoder.sv =====
// binhex_stream_decoder: top level with input register, decoder and result register.
// Depends on bhx_pkg, bhx_classify and bhx_core.
//
// BinHex 4.0 text decoder taking one character per beat and giving at most one
// result beat per character (data byte with repeat count, end marker or abort).
// Sustained rate is one character per clock unless a result waits on out_stall; a
// character passes from the input register through the classify lookup and decode
// logic to the result register. The input side
// keeps taking beats while a result waits in the output register, as long as the
// characters in flight produce no result or the output drains. cfg_data sets the
// permissive flag and must be written only while no character is in flight.
module binhex_stream_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_enc_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_repeat_res,
  output logic [1:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic           s1_valid_r, s1_valid_nxt;
  logic [7:0]     s1_char_r;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_data_r;
  logic [7:0]     out_rep_r;
  logic [1:0]     out_status_r;
  logic           perm_r;
  logic           advance;
  logic           accept;
  bhx_pkg::code_t code;
  bhx_pkg::res_t  res;

  bhx_classify u_classify (
    .ch   (s1_char_r),
    .code (code)
  );

  bhx_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .code       (code),
    .permissive (perm_r),
    .res        (res)
  );

  assign advance   = s1_valid_r && (!res.valid || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = !s1_valid_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (advance && res.valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      perm_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        perm_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_char_r <= in_enc_char;
    end
    if (advance && res.valid) begin
      out_data_r   <= res.data_byte;
      out_rep_r    <= res.repeat_res;
      out_status_r <= res.status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = out_data_r;
  assign out_repeat_res = out_rep_r;
  assign out_status     = out_status_r;

endmodule
